@@ hw/rtl/double_hash_key_counter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double hash key counter
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_KEY_COUNTER_UNIT_DEFINES_SVH
`define DOUBLE_HASH_KEY_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHKC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dhkc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DHKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dhkc check failed");

`endif

@@ hw/rtl/dhkc_pkg.sv @@
// ----------------------------------------------------------------------------
// dhkc_pkg
// Types, widths and result codes shared by the double hash key counter.
// ----------------------------------------------------------------------------
package dhkc_pkg;

	localparam int TABLE_SIZE_DEF    = 59;
	localparam int KEY_MAX_BYTES_DEF = 19;
	localparam int KEY_BIAS          = 65;

	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 16;
	localparam int SLOT_W   = 6;
	localparam int PROBE_W  = 6;
	localparam int TOTAL_W  = 32;
	localparam int CHAR_W   = 8;

	localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INC       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic              func;
		logic [CHAR_W-1:0] key_char;
		logic              key_last;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  key_count;
		logic [SLOT_W-1:0]   slot_index;
		logic [PROBE_W-1:0]  probe_count;
		logic [TOTAL_W-1:0]  total_collisions;
		logic [TOTAL_W-1:0]  new_key_collisions;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic start;
		logic rd;
		logic byte_rd;
		logic advance;
		logic collide;
		logic res_new;
		logic res_match;
		logic res_empty;
		logic res_exhaust;
		logic copy;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic occ_zero;
		logic len_eq;
		logic byte_eq;
		logic byte_last;
		logic copy_last;
		logic probe_last;
		logic func;
		logic out_free;
	} stat_t;

endpackage

@@ hw/rtl/dhkc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dhkc_ctrl
// Sequencer that walks the probe chain, the byte compares and the byte copy of one key.
// ----------------------------------------------------------------------------
module dhkc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	input  dhkc_pkg::stat_t stat,
	output dhkc_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_COPY  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       miss;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		miss    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_last) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.occ_zero) begin
					if (stat.func) begin
						cmd.res_empty = 1'b1;
						state_d       = S_FIN;
					end else begin
						cmd.res_new = 1'b1;
						state_d     = S_COPY;
					end
				end else if (stat.len_eq) begin
					cmd.byte_rd = 1'b1;
					state_d     = S_CMP;
				end else begin
					miss = 1'b1;
				end
			end
			S_CMP: begin
				if (!stat.byte_eq) begin
					miss = 1'b1;
				end else if (stat.byte_last) begin
					cmd.res_match = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.byte_rd = 1'b1;
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (stat.copy_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// An occupied slot holding another key: count it and move on, or give up.
		if (miss) begin
			cmd.collide = 1'b1;
			if (stat.probe_last) begin
				cmd.res_exhaust = 1'b1;
				state_d         = S_FIN;
			end else begin
				cmd.advance = 1'b1;
				state_d     = S_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/dhkc_datapath.sv @@
// ----------------------------------------------------------------------------
// dhkc_datapath
// Key buffer, running hashes, slot stores, totals and the output register.
// ----------------------------------------------------------------------------
module dhkc_datapath #(
	parameter int TABLE_SIZE    = dhkc_pkg::TABLE_SIZE_DEF,
	parameter int KEY_MAX_BYTES = dhkc_pkg::KEY_MAX_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dhkc_pkg::in_word_t  in_data,
	input  dhkc_pkg::cmd_t      cmd,
	output dhkc_pkg::stat_t     stat,
	input  logic                out_ready,
	output logic                out_valid,
	output dhkc_pkg::out_word_t out_data
);

	localparam int SW    = $clog2(TABLE_SIZE);
	localparam int LW    = $clog2(KEY_MAX_BYTES + 1);
	localparam int JW    = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
	localparam int DEPTH = TABLE_SIZE * KEY_MAX_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = $clog2(TABLE_SIZE + 1);
	localparam int CW    = dhkc_pkg::COUNT_W;
	localparam int TW    = dhkc_pkg::TOTAL_W;
	localparam int BW    = dhkc_pkg::CHAR_W;

	// Residues of (byte - bias) modulo the table size and modulo one less.
	logic [SW-1:0] hm_tab [256];
	logic [SW-1:0] sm_tab [256];

	for (genvar g = 0; g < 256; g++) begin : g_tab
		localparam int RH = ((g - dhkc_pkg::KEY_BIAS) % TABLE_SIZE + TABLE_SIZE) % TABLE_SIZE;
		localparam int RS = ((g - dhkc_pkg::KEY_BIAS) % (TABLE_SIZE - 1) + TABLE_SIZE - 1)
			% (TABLE_SIZE - 1);
		assign hm_tab[g] = SW'(RH);
		assign sm_tab[g] = SW'(RS);
	end

	// Stores.
	logic [BW-1:0] pend_mem [KEY_MAX_BYTES];
	logic [BW-1:0] key_mem  [DEPTH];
	logic [LW-1:0] len_mem  [TABLE_SIZE];
	logic [CW-1:0] occ_mem  [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] vld_q;

	// Control registers.
	logic [LW-1:0] pend_len_q;
	logic [SW-1:0] home_q;
	logic [SW-1:0] step_q;
	logic          func_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] i_q;
	logic [LW-1:0] j_q;
	logic [TW-1:0] coll_q;
	logic [TW-1:0] nk_q;
	logic          out_valid_q;

	// Payload registers.
	logic [CW-1:0] occ_rd_s;
	logic [LW-1:0] len_rd_s;
	logic [BW-1:0] kb_s;
	logic [BW-1:0] pb_s;
	logic [dhkc_pkg::STATUS_W-1:0] res_status_q;
	logic [CW-1:0] res_count_q;
	logic [PW-1:0] res_probes_q;
	dhkc_pkg::out_word_t out_data_q;

	logic [SW:0]   h_sum;
	logic [SW-1:0] h_next;
	logic [SW:0]   s_sum;
	logic [SW:0]   s_red;
	logic [SW-1:0] s_next;
	logic [SW:0]   n_sum;
	logic [SW-1:0] n_next;
	logic [AW-1:0] addr;
	logic [TW:0]   nk_sum;
	logic [CW-1:0] occ_inc;

	always_comb begin
		h_sum  = {1'b0, home_q} + {1'b0, hm_tab[in_data.key_char]};
		h_next = (h_sum >= (SW+1)'(TABLE_SIZE)) ? SW'(h_sum - (SW+1)'(TABLE_SIZE))
			: h_sum[SW-1:0];
		s_sum  = {1'b0, step_q} + {1'b0, sm_tab[in_data.key_char]};
		s_red  = (s_sum >= (SW+1)'(TABLE_SIZE - 1)) ? (s_sum - (SW+1)'(TABLE_SIZE - 1)) : s_sum;
		s_next = SW'(s_red) + SW'(1);
		n_sum  = {1'b0, slot_q} + {1'b0, step_q};
		n_next = (n_sum >= (SW+1)'(TABLE_SIZE)) ? SW'(n_sum - (SW+1)'(TABLE_SIZE))
			: n_sum[SW-1:0];
		addr   = AW'(int'(slot_q) * KEY_MAX_BYTES + int'(j_q));
		nk_sum = {1'b0, nk_q} + (TW+1)'(i_q);
		occ_inc = (occ_rd_s == '1) ? occ_rd_s : occ_rd_s + CW'(1);
	end

	assign stat.occ_zero   = (occ_rd_s == '0);
	assign stat.len_eq     = (len_rd_s == pend_len_q);
	assign stat.byte_eq    = (kb_s == pb_s);
	assign stat.byte_last  = (j_q == pend_len_q);
	assign stat.copy_last  = (LW'(j_q + LW'(1)) == pend_len_q);
	assign stat.probe_last = (i_q == SW'(TABLE_SIZE - 1));
	assign stat.func       = func_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_len_q  <= '0;
			home_q      <= '0;
			step_q      <= '0;
			func_q      <= 1'b0;
			slot_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			coll_q      <= '0;
			nk_q        <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.finish) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.take) begin
				func_q <= in_data.func;
				if (pend_len_q < LW'(KEY_MAX_BYTES)) begin
					pend_len_q <= pend_len_q + LW'(1);
					home_q     <= h_next;
					step_q     <= s_next;
				end
			end
			if (cmd.start) begin
				slot_q <= home_q;
				i_q    <= '0;
			end
			if (cmd.rd) begin
				j_q <= '0;
			end
			if (cmd.byte_rd || cmd.copy) begin
				j_q <= j_q + LW'(1);
			end
			if (cmd.advance) begin
				slot_q <= n_next;
				i_q    <= i_q + SW'(1);
			end
			if (cmd.collide && !func_q && (coll_q != '1)) begin
				coll_q <= coll_q + TW'(1);
			end
			if (cmd.res_new) begin
				vld_q[slot_q] <= 1'b1;
				nk_q <= nk_sum[TW] ? '1 : nk_sum[TW-1:0];
			end
			if (cmd.finish) begin
				pend_len_q  <= '0;
				home_q      <= '0;
				step_q      <= '0;
				out_valid_q <= 1'b1;
			end
		end
	end

	// Stores and payload.
	always_ff @(posedge clk) begin
		if (cmd.take && (pend_len_q < LW'(KEY_MAX_BYTES))) begin
			pend_mem[pend_len_q[JW-1:0]] <= in_data.key_char;
		end
		if (cmd.rd) begin
			occ_rd_s <= vld_q[slot_q] ? occ_mem[slot_q] : '0;
			len_rd_s <= len_mem[slot_q];
		end
		if (cmd.byte_rd) begin
			kb_s <= key_mem[addr];
			pb_s <= pend_mem[j_q[JW-1:0]];
		end
		if (cmd.copy) begin
			key_mem[addr] <= pend_mem[j_q[JW-1:0]];
		end
		if (cmd.res_new) begin
			occ_mem[slot_q] <= CW'(1);
			len_mem[slot_q] <= pend_len_q;
			res_status_q    <= dhkc_pkg::ST_NEW;
			res_count_q     <= CW'(1);
			res_probes_q    <= PW'(i_q);
		end
		if (cmd.res_match) begin
			res_probes_q <= PW'(i_q);
			if (!func_q) begin
				occ_mem[slot_q] <= occ_inc;
				res_status_q    <= dhkc_pkg::ST_INC;
				res_count_q     <= occ_inc;
			end else begin
				res_status_q <= dhkc_pkg::ST_FOUND;
				res_count_q  <= occ_rd_s;
			end
		end
		if (cmd.res_empty) begin
			res_status_q <= dhkc_pkg::ST_NOT_FOUND;
			res_count_q  <= '0;
			res_probes_q <= PW'(i_q);
		end
		if (cmd.res_exhaust) begin
			res_status_q <= func_q ? dhkc_pkg::ST_NOT_FOUND : dhkc_pkg::ST_FULL;
			res_count_q  <= '0;
			res_probes_q <= PW'(TABLE_SIZE);
		end
		if (cmd.finish) begin
			out_data_q.status             <= res_status_q;
			out_data_q.key_count          <= res_count_q;
			out_data_q.slot_index         <= dhkc_pkg::SLOT_W'(slot_q);
			out_data_q.probe_count        <= dhkc_pkg::PROBE_W'(res_probes_q);
			out_data_q.total_collisions   <= coll_q;
			out_data_q.new_key_collisions <= nk_q;
		end
	end

endmodule

@@ hw/rtl/double_hash_key_counter_unit.sv @@
// ----------------------------------------------------------------------------
// double_hash_key_counter_unit
// Open-addressing key counter with double hashing, fed one key byte per word.
// ----------------------------------------------------------------------------
// Keys arrive one byte per input word; the word flagged key_last closes the key
// and starts a table operation (insert-or-count, or search, as chosen by func on
// that word), which yields exactly one output word. A byte that does not close a
// key is taken while idle and yields nothing; bytes beyond KEY_MAX_BYTES are
// dropped without touching the hashes. A closing byte is followed by a start
// step, then for every slot probed a slot read and a check, one compare step per
// stored byte compared, and, when a new key is placed, one copy step per key
// byte; each compare and each copy moves one byte of the key byte memory.
// At most TABLE_SIZE slots are probed, and a finish step ends the operation.
// No input word is accepted while a table operation runs. The finished word sits
// in an output register, so key bytes of the next key are accepted while it
// waits; an operation holds in its finish step only while the previous result
// has not yet been taken. There is no clearing pass after reset: slot occupancy
// lives in flip-flops that reset clears at once.
// ----------------------------------------------------------------------------
module double_hash_key_counter_unit #(
	parameter int TABLE_SIZE    = dhkc_pkg::TABLE_SIZE_DEF,
	parameter int KEY_MAX_BYTES = dhkc_pkg::KEY_MAX_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dhkc_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dhkc_pkg::out_word_t out_data
);

	// Command and status between the sequencer and the datapath.
	dhkc_pkg::cmd_t  cmd;
	dhkc_pkg::stat_t stat;

	// The sequencer owns the input handshake; it accepts only while idle.
	dhkc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.key_last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds every store and the output register.
	dhkc_datapath #(
		.TABLE_SIZE    (TABLE_SIZE),
		.KEY_MAX_BYTES (KEY_MAX_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

@@ hw/rtl/dhkc_checker.sv @@
// ----------------------------------------------------------------------------
// dhkc_checker
// Port-level checks on the double hash key counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_hash_key_counter_unit_defines.svh"

module dhkc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input dhkc_pkg::in_word_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input dhkc_pkg::out_word_t out_data
);

	// A stalled result word holds.
	`DHKC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// Not found and table full carry no count.
	`DHKC_ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && (out_data.status == dhkc_pkg::ST_NOT_FOUND || out_data.status == dhkc_pkg::ST_FULL), out_data.key_count == '0)

	// A newly placed key has been seen once.
	`DHKC_ASSERT_IMPL(a_new_one, clk, arst_n, out_valid && out_data.status == dhkc_pkg::ST_NEW, out_data.key_count == 16'd1)

	// A key that is found or counted has a non-zero count.
	`DHKC_ASSERT_IMPL(a_hit_count, clk, arst_n, out_valid && (out_data.status == dhkc_pkg::ST_FOUND || out_data.status == dhkc_pkg::ST_INC), out_data.key_count != '0)

endmodule

bind double_hash_key_counter_unit dhkc_checker u_dhkc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
